// ----- sv/stc_pkg.sv -----
`timescale 1ns / 1ps

package stc_pkg;

    // Scanner modes, one-hot
    typedef enum logic [6:0] {
        MODE_IDLE    = 7'b0000001,
        MODE_COMMENT = 7'b0000010,
        MODE_STRING  = 7'b0000100,
        MODE_NUMBER  = 7'b0001000,
        MODE_IDENT   = 7'b0010000,
        MODE_OPER    = 7'b0100000,
        MODE_HALT    = 7'b1000000
    } t_mode;

    // Character classes found by the front end
    typedef enum logic [2:0] {
        CLS_SPACE,
        CLS_HASH,
        CLS_QUOTE,
        CLS_DIGIT,
        CLS_LETTER,
        CLS_PUNCT,
        CLS_OPER,
        CLS_OTHER
    } t_cls;

    // Token kinds
    localparam logic [4:0] KIND_END        = 5'd0;
    localparam logic [4:0] KIND_INT        = 5'd1;
    localparam logic [4:0] KIND_STR        = 5'd2;
    localparam logic [4:0] KIND_IDENT      = 5'd3;
    localparam logic [4:0] KIND_KW_BASE    = 5'd4;
    localparam logic [4:0] KIND_PUNCT_BASE = 5'd8;
    localparam logic [4:0] KIND_OPER_BASE  = 5'd13;  // plus operator code 1..5
    localparam logic [4:0] KIND_BAD_CHAR   = 5'd19;
    localparam logic [4:0] KIND_BAD_OPER   = 5'd20;

    localparam logic [2:0] OPER_CODE_MAX   = 3'd5;
    localparam int         QUEUE_DEPTH     = 4;

    // One classified byte waiting for the back end
    typedef struct packed {
        logic       eot;
        logic [7:0] ch;
        t_cls       cls;
        logic [2:0] sub;   // index within punctuation or operator set
        logic       nl;
    } t_item;

    // One token as presented on the output
    typedef struct packed {
        logic [4:0]  kind;
        logic [31:0] start;
        logic [15:0] len;
        logic [31:0] value;
    } t_token;

    function automatic logic [3:0] kw_len(input logic [1:0] k);
        case (k)
            2'd0:    return 4'd3;
            2'd1:    return 4'd2;
            2'd2:    return 4'd5;
            default: return 4'd8;
        endcase
    endfunction

    // Keywords: var, if, print, function
    function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] idx);
        case ({k, idx})
            {2'd0, 3'd0}: return "v";
            {2'd0, 3'd1}: return "a";
            {2'd0, 3'd2}: return "r";
            {2'd1, 3'd0}: return "i";
            {2'd1, 3'd1}: return "f";
            {2'd2, 3'd0}: return "p";
            {2'd2, 3'd1}: return "r";
            {2'd2, 3'd2}: return "i";
            {2'd2, 3'd3}: return "n";
            {2'd2, 3'd4}: return "t";
            {2'd3, 3'd0}: return "f";
            {2'd3, 3'd1}: return "u";
            {2'd3, 3'd2}: return "n";
            {2'd3, 3'd3}: return "c";
            {2'd3, 3'd4}: return "t";
            {2'd3, 3'd5}: return "i";
            {2'd3, 3'd6}: return "o";
            {2'd3, 3'd7}: return "n";
            default:      return 8'h00;
        endcase
    endfunction

endpackage

// ----- sv/script_token_scanner.sv -----
// A token beat goes out after its byte passes the byte queue and the output register.
// The front end takes one byte per cycle while the queue has room; a byte that closes
// one token and reports another (punctuation, bad character or end mark) holds the
// back end for both beats; the four-entry byte queue absorbs short runs of such bytes.
// Reset (i_rst_n low at a clock edge): empty the queue, drop the output beat,
// return the scanner to idle at offset 0 with all keyword candidates live.
`timescale 1ns / 1ps

module script_token_scanner
    import stc_pkg::*;
#(
    parameter int POSITION_BITS = 32,
    parameter int LENGTH_BITS   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_text,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [4:0]  o_token_kind,
    output logic [31:0] o_start_offset,
    output logic [15:0] o_token_length,
    output logic [31:0] o_int_value,
    output logic        o_last_of_run
);

    // Front end: take a byte whenever the queue has room and tag its class.
    logic  q_full;
    logic  q_push;
    t_item q_in;

    // Queue: four classified bytes, so the front keeps streaming while
    // the back waits on the output or issues two tokens for one byte.
    logic  q_valid;
    logic  q_pop;
    t_item q_head;

    stc_front u_front (
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_in_byte     (i_in_byte),
        .i_end_of_text (i_end_of_text),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_item        (q_in)
    );

    stc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_head)
    );

    // Back end: the scanner state machine. It closes the pending token,
    // examines the byte afresh, saturates counts and integer values, and
    // drives a registered output beat with last_of_run on the final token
    // of each byte.
    stc_back #(
        .POSITION_BITS (POSITION_BITS),
        .LENGTH_BITS   (LENGTH_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item_valid   (q_valid),
        .i_item         (q_head),
        .o_pop          (q_pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_token_kind   (o_token_kind),
        .o_start_offset (o_start_offset),
        .o_token_length (o_token_length),
        .o_int_value    (o_int_value),
        .o_last_of_run  (o_last_of_run)
    );

endmodule

// ----- sv/stc_front.sv -----
`timescale 1ns / 1ps

module stc_front
    import stc_pkg::*;
(
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_text,
    input  logic       i_q_full,
    output logic       o_push,
    output t_item      o_item
);

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    // Classify the byte once so the back end only looks at the class
    always_comb begin
        o_item.eot = i_end_of_text;
        o_item.ch  = i_in_byte;
        o_item.nl  = (i_in_byte == 8'h0A);
        o_item.sub = 3'd0;
        case (i_in_byte) inside
            " ", 8'h09, 8'h0D, 8'h0A: o_item.cls = CLS_SPACE;
            "#":                      o_item.cls = CLS_HASH;
            8'h22:                    o_item.cls = CLS_QUOTE;
            ["0":"9"]:                o_item.cls = CLS_DIGIT;
            ["a":"z"], ["A":"Z"]:     o_item.cls = CLS_LETTER;
            ",": begin o_item.cls = CLS_PUNCT; o_item.sub = 3'd0; end
            ";": begin o_item.cls = CLS_PUNCT; o_item.sub = 3'd1; end
            "(": begin o_item.cls = CLS_PUNCT; o_item.sub = 3'd2; end
            ")": begin o_item.cls = CLS_PUNCT; o_item.sub = 3'd3; end
            "{": begin o_item.cls = CLS_PUNCT; o_item.sub = 3'd4; end
            "}": begin o_item.cls = CLS_PUNCT; o_item.sub = 3'd5; end
            "+": begin o_item.cls = CLS_OPER;  o_item.sub = 3'd0; end
            "-": begin o_item.cls = CLS_OPER;  o_item.sub = 3'd1; end
            "*": begin o_item.cls = CLS_OPER;  o_item.sub = 3'd2; end
            "/": begin o_item.cls = CLS_OPER;  o_item.sub = 3'd3; end
            "=": begin o_item.cls = CLS_OPER;  o_item.sub = 3'd4; end
            default:                  o_item.cls = CLS_OTHER;
        endcase
    end

endmodule

// ----- sv/stc_queue.sv -----
`timescale 1ns / 1ps

module stc_queue
    import stc_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [CNT_W-1:0]   r_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= wrap_inc(r_wr);
            if (do_pop)  r_rd <= wrap_inc(r_rd);
            if (do_push && !do_pop)      r_cnt <= r_cnt + 1'b1;
            else if (do_pop && !do_push) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

// ----- sv/stc_back.sv -----
`timescale 1ns / 1ps

module stc_back
    import stc_pkg::*;
#(
    parameter int POSITION_BITS = 32,
    parameter int LENGTH_BITS   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_item_valid,
    input  t_item       i_item,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [4:0]  o_token_kind,
    output logic [31:0] o_start_offset,
    output logic [15:0] o_token_length,
    output logic [31:0] o_int_value,
    output logic        o_last_of_run
);

    t_mode                    r_mode, n_mode;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [POSITION_BITS-1:0] r_start, n_start;
    logic [LENGTH_BITS-1:0]   r_count, n_count;
    logic [31:0]              r_acc, n_acc;
    logic [3:0]               r_kw, n_kw;
    logic [2:0]               r_op, n_op;
    logic                     r_second, n_second;

    t_token                   r_out;
    logic                     r_last;
    logic                     r_ovalid;

    t_token                   pend_tok, tok_a, tok_b, ld_tok;
    logic                     pend_v, pend_halt, a_v, b_v, do_disp;
    logic                     adv, load, ld_last, out_free;
    logic [LENGTH_BITS-1:0]   count_inc;
    logic [35:0]              acc_prod;
    logic [31:0]              acc_next;

    function automatic logic [31:0] to_off(input logic [POSITION_BITS-1:0] p);
        logic [63:0] w;
        w = 64'(p);
        return w[31:0];
    endfunction

    function automatic logic [15:0] to_len(input logic [LENGTH_BITS-1:0] c);
        logic [31:0] w;
        w = 32'(c);
        return w[15:0];
    endfunction

    function automatic t_token mk(input logic [4:0] kind, input logic [31:0] start,
                                 input logic [15:0] len, input logic [31:0] value);
        t_token t;
        t.kind  = kind;
        t.start = start;
        t.len   = len;
        t.value = value;
        return t;
    endfunction

    // Drop keywords whose next character does not match
    function automatic logic [3:0] narrow(input logic [3:0] kw,
                                          input logic [LENGTH_BITS-1:0] cnt,
                                          input logic [7:0] c);
        logic [3:0] res;
        res = kw;
        for (int k = 0; k < 4; k++) begin
            if (!(cnt < LENGTH_BITS'(kw_len(2'(k))) && kw_char(2'(k), cnt[2:0]) == c)) begin
                res[k] = 1'b0;
            end
        end
        return res;
    endfunction

    assign count_inc = (r_count == '1) ? r_count : r_count + 1'b1;
    assign acc_prod  = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) + 36'(i_item.ch[3:0]);
    assign acc_next  = (acc_prod[35:32] != 4'd0) ? 32'hFFFF_FFFF : acc_prod[31:0];

    // Token that the current mode holds open
    always_comb begin
        pend_v    = 1'b0;
        pend_halt = 1'b0;
        pend_tok  = mk(KIND_IDENT, to_off(r_start), to_len(r_count), 32'd0);
        case (r_mode)
            MODE_NUMBER: begin
                pend_v         = 1'b1;
                pend_tok.kind  = KIND_INT;
                pend_tok.value = r_acc;
            end
            MODE_STRING: begin
                pend_v        = 1'b1;
                pend_tok.kind = KIND_STR;
            end
            MODE_IDENT: begin
                pend_v = 1'b1;
                for (int k = 0; k < 4; k++) begin
                    if (r_kw[k] && r_count == LENGTH_BITS'(kw_len(2'(k)))) begin
                        pend_tok.kind = KIND_KW_BASE + 5'(k);
                    end
                end
            end
            MODE_OPER: begin
                pend_v = 1'b1;
                if (r_count == LENGTH_BITS'(1) && r_op >= 3'd1 && r_op <= OPER_CODE_MAX) begin
                    pend_tok.kind = KIND_OPER_BASE + 5'(r_op);
                    pend_tok.len  = 16'd1;
                end else begin
                    pend_tok.kind = KIND_BAD_OPER;
                    pend_halt     = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Scanner step for the head item: up to two tokens and the next state
    always_comb begin
        a_v     = 1'b0;
        b_v     = 1'b0;
        tok_a   = pend_tok;
        tok_b   = mk(KIND_END, to_off(r_pos), 16'd0, 32'd0);
        do_disp = 1'b0;
        n_mode  = r_mode;
        n_pos   = r_pos;
        n_start = r_start;
        n_count = r_count;
        n_acc   = r_acc;
        n_kw    = r_kw;
        n_op    = r_op;
        if (i_item.eot) begin
            if (r_mode != MODE_HALT && r_mode != MODE_COMMENT) a_v = pend_v;
            b_v     = 1'b1;
            n_mode  = MODE_IDLE;
            n_pos   = '0;
            n_start = '0;
            n_count = '0;
            n_acc   = '0;
            n_kw    = 4'hF;
            n_op    = '0;
        end else begin
            n_pos = r_pos + 1'b1;
            case (r_mode)
                MODE_HALT: ;
                MODE_COMMENT: begin
                    if (i_item.nl) n_mode = MODE_IDLE;
                end
                MODE_STRING: begin
                    if (i_item.cls == CLS_QUOTE) begin
                        a_v    = 1'b1;
                        n_mode = MODE_IDLE;
                    end else begin
                        n_count = count_inc;
                    end
                end
                MODE_NUMBER: begin
                    if (i_item.cls == CLS_DIGIT) begin
                        n_acc   = acc_next;
                        n_count = count_inc;
                    end else begin
                        a_v     = 1'b1;
                        do_disp = 1'b1;
                    end
                end
                MODE_IDENT: begin
                    if (i_item.cls == CLS_LETTER) begin
                        n_kw    = narrow(r_kw, r_count, i_item.ch);
                        n_count = count_inc;
                    end else begin
                        a_v     = 1'b1;
                        do_disp = 1'b1;
                    end
                end
                MODE_OPER: begin
                    if (i_item.cls == CLS_OPER) begin
                        n_count = count_inc;
                    end else begin
                        a_v = 1'b1;
                        if (pend_halt) n_mode = MODE_HALT;
                        else           do_disp = 1'b1;
                    end
                end
                default: do_disp = 1'b1;
            endcase
            if (do_disp) begin
                n_mode = MODE_IDLE;
                case (i_item.cls)
                    CLS_SPACE: ;
                    CLS_HASH:  n_mode = MODE_COMMENT;
                    CLS_QUOTE: begin
                        n_mode  = MODE_STRING;
                        n_start = r_pos + 1'b1;
                        n_count = '0;
                    end
                    CLS_DIGIT: begin
                        n_mode  = MODE_NUMBER;
                        n_start = r_pos;
                        n_count = LENGTH_BITS'(1);
                        n_acc   = 32'(i_item.ch[3:0]);
                    end
                    CLS_LETTER: begin
                        n_mode  = MODE_IDENT;
                        n_start = r_pos;
                        n_kw    = narrow(4'hF, '0, i_item.ch);
                        n_count = LENGTH_BITS'(1);
                    end
                    CLS_PUNCT: begin
                        b_v   = 1'b1;
                        tok_b = mk(KIND_PUNCT_BASE + 5'(i_item.sub), to_off(r_pos), 16'd1, 32'd0);
                    end
                    CLS_OPER: begin
                        n_mode  = MODE_OPER;
                        n_start = r_pos;
                        n_count = LENGTH_BITS'(1);
                        n_op    = i_item.sub + 3'd1;
                    end
                    default: begin
                        b_v    = 1'b1;
                        tok_b  = mk(KIND_BAD_CHAR, to_off(r_pos), 16'd1, 32'd0);
                        n_mode = MODE_HALT;
                    end
                endcase
            end
        end
    end

    // Issue: hold the head item while its first of two tokens goes out
    assign out_free = !r_ovalid || i_ready;

    always_comb begin
        adv      = 1'b0;
        load     = 1'b0;
        ld_tok   = a_v ? tok_a : tok_b;
        ld_last  = 1'b1;
        n_second = r_second;
        if (i_item_valid) begin
            if (!a_v && !b_v) begin
                adv = 1'b1;
            end else if (out_free) begin
                load = 1'b1;
                if (a_v && b_v && !r_second) begin
                    ld_last  = 1'b0;
                    n_second = 1'b1;
                end else begin
                    if (a_v && b_v) ld_tok = tok_b;
                    adv      = 1'b1;
                    n_second = 1'b0;
                end
            end
        end
    end

    assign o_pop = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_pos    <= '0;
            r_start  <= '0;
            r_count  <= '0;
            r_acc    <= '0;
            r_kw     <= 4'hF;
            r_op     <= '0;
            r_second <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_second <= n_second;
            if (adv) begin
                r_mode  <= n_mode;
                r_pos   <= n_pos;
                r_start <= n_start;
                r_count <= n_count;
                r_acc   <= n_acc;
                r_kw    <= n_kw;
                r_op    <= n_op;
            end
            if (load)          r_ovalid <= 1'b1;
            else if (i_ready)  r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out  <= ld_tok;
            r_last <= ld_last;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_token_kind   = r_out.kind;
    assign o_start_offset = r_out.start;
    assign o_token_length = r_out.len;
    assign o_int_value    = r_out.value;
    assign o_last_of_run  = r_last;

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import stc_pkg::*;

    // Character codes used by both the predictor and the text generator
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // One token beat as it appears on the output side
    typedef struct packed {
        logic [4:0]  kind;
        logic [31:0] start;
        logic [15:0] len;
        logic [31:0] value;
        logic        last;
    } t_beat;

    // Scoreboard: tracks the scanner state per accepted byte beat and
    // holds the token beats that those bytes must produce, oldest first.
    class scan_scoreboard;
        t_mode       mode;
        logic [31:0] pos;
        logic [31:0] tok_start;
        logic [15:0] tok_count;
        logic [31:0] acc;
        logic [3:0]  kw_live;
        logic [2:0]  oper_code;
        string       kw_word[4];

        t_beat       expected_tokens[$];
        t_beat       step_tokens[$];
        int          errors;
        int          checked;
        int          items;

        function new();
            kw_word = '{"var", "if", "print", "function"};
            errors  = 0;
            checked = 0;
            items   = 0;
            clear_state();
        endfunction

        function void clear_state();
            mode      = MODE_IDLE;
            pos       = '0;
            tok_start = '0;
            tok_count = '0;
            acc       = '0;
            kw_live   = 4'hF;
            oper_code = '0;
        endfunction

        function void push_token(logic [4:0] kind, logic [31:0] start,
                                 logic [15:0] len, logic [31:0] value);
            t_beat t;
            if (step_tokens.size() >= 2) return;
            t = '{kind: kind, start: start, len: len, value: value, last: 1'b0};
            step_tokens.push_back(t);
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit is_letter(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        function int punct_index(logic [7:0] c);
            case (c)
                ",":     return 0;
                ";":     return 1;
                "(":     return 2;
                ")":     return 3;
                "{":     return 4;
                "}":     return 5;
                default: return -1;
            endcase
        endfunction

        function int oper_index(logic [7:0] c);
            case (c)
                "+":     return 0;
                "-":     return 1;
                "*":     return 2;
                "/":     return 3;
                "=":     return 4;
                default: return -1;
            endcase
        endfunction

        function void bump();
            if (tok_count != COUNT_MAX) tok_count++;
        endfunction

        // Drop every keyword whose next letter differs from c
        function void narrow(logic [7:0] c);
            for (int k = 0; k < 4; k++) begin
                if (tok_count >= kw_word[k].len() || kw_word[k][tok_count] != c)
                    kw_live[k] = 1'b0;
            end
        endfunction

        // Report the token in progress; a bad operator run halts the scan
        function void flush_token();
            logic [4:0] kind;
            case (mode)
                MODE_NUMBER: push_token(KIND_INT, tok_start, tok_count, acc);
                MODE_STRING: push_token(KIND_STR, tok_start, tok_count, '0);
                MODE_IDENT: begin
                    kind = KIND_IDENT;
                    for (int k = 0; k < 4; k++)
                        if (kw_live[k] && tok_count == kw_word[k].len())
                            kind = KIND_KW_BASE + 5'(k);
                    push_token(kind, tok_start, tok_count, '0);
                end
                MODE_OPER: begin
                    if (tok_count == 16'd1 && oper_code >= 3'd1 && oper_code <= OPER_CODE_MAX)
                    begin
                        push_token(KIND_OPER_BASE + 5'(oper_code), tok_start, 16'd1, '0);
                    end else begin
                        push_token(KIND_BAD_OPER, tok_start, tok_count, '0);
                        mode = MODE_HALT;
                        return;
                    end
                end
                default: ;
            endcase
            mode = MODE_IDLE;
        endfunction

        // Look at a byte between tokens
        function void start_token(logic [7:0] c);
            int idx;
            if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) return;
            if (c == CH_HASH) begin
                mode = MODE_COMMENT;
                return;
            end
            if (c == CH_QUOTE) begin
                mode      = MODE_STRING;
                tok_start = pos + 32'd1;
                tok_count = '0;
                return;
            end
            if (is_digit(c)) begin
                mode      = MODE_NUMBER;
                tok_start = pos;
                tok_count = 16'd1;
                acc       = 32'(c - "0");
                return;
            end
            if (is_letter(c)) begin
                mode      = MODE_IDENT;
                tok_start = pos;
                tok_count = '0;
                kw_live   = 4'hF;
                narrow(c);
                tok_count = 16'd1;
                return;
            end
            idx = punct_index(c);
            if (idx >= 0) begin
                push_token(KIND_PUNCT_BASE + 5'(idx), pos, 16'd1, '0);
                return;
            end
            idx = oper_index(c);
            if (idx >= 0) begin
                mode      = MODE_OPER;
                tok_start = pos;
                tok_count = 16'd1;
                oper_code = 3'(idx + 1);
                return;
            end
            push_token(KIND_BAD_CHAR, pos, 16'd1, '0);
            mode = MODE_HALT;
        endfunction

        // Advance the scanner by one accepted byte beat
        function void note_byte(logic [7:0] c, logic eot);
            longint unsigned v;
            step_tokens.delete();
            items++;
            if (eot) begin
                if (mode != MODE_HALT && mode != MODE_COMMENT) flush_token();
                push_token(KIND_END, pos, 16'd0, '0);
                clear_state();
            end else begin
                case (mode)
                    MODE_HALT: ;
                    MODE_COMMENT: if (c == CH_LF) mode = MODE_IDLE;
                    MODE_STRING: begin
                        if (c == CH_QUOTE) flush_token();
                        else bump();
                    end
                    MODE_NUMBER: begin
                        if (is_digit(c)) begin
                            v   = 64'(acc) * 64'd10 + 64'(c - "0");
                            acc = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
                            bump();
                        end else begin
                            flush_token();
                            start_token(c);
                        end
                    end
                    MODE_IDENT: begin
                        if (is_letter(c)) begin
                            narrow(c);
                            bump();
                        end else begin
                            flush_token();
                            start_token(c);
                        end
                    end
                    MODE_OPER: begin
                        if (oper_index(c) >= 0) begin
                            bump();
                        end else begin
                            flush_token();
                            if (mode != MODE_HALT) start_token(c);
                        end
                    end
                    default: begin
                        mode = MODE_IDLE;
                        start_token(c);
                    end
                endcase
                pos = pos + 32'd1;
            end
            if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
            foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
        endfunction

        function int pending();
            return expected_tokens.size();
        endfunction

        // Compare one accepted token beat against the oldest expectation
        function void check_token(logic [4:0] kind, logic [31:0] start, logic [15:0] len,
                                  logic [31:0] value, logic last);
            t_beat got;
            t_beat want;
            got = '{kind: kind, start: start, len: len, value: value, last: last};
            checked++;
            if (expected_tokens.size() == 0) begin
                errors++;
                $display("%0t: unexpected token: expected none,", $time);
                $display("    got kind %0d start %0d len %0d value %0d last %0b",
                         kind, start, len, value, last);
                return;
            end
            want = expected_tokens.pop_front();
            if (got !== want) begin
                errors++;
                $display("%0t: token mismatch: expected kind %0d start %0d len %0d value %0d last %0b,",
                         $time, want.kind, want.start, want.len, want.value, want.last);
                $display("    got kind %0d start %0d len %0d value %0d last %0b",
                         got.kind, got.start, got.len, got.value, got.last);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_in_byte;
    logic        i_end_of_text;
    logic        o_valid;
    logic        i_ready;
    logic [4:0]  o_token_kind;
    logic [31:0] o_start_offset;
    logic [15:0] o_token_length;
    logic [31:0] o_int_value;
    logic        o_last_of_run;

    scan_scoreboard sb = new();

    // Idle percentages per side, and a request for a long receiver hold-off
    int    send_idle = 0;
    int    recv_idle = 0;
    int    hold_req  = 0;
    string kw_names[4] = '{"var", "if", "print", "function"};

    script_token_scanner dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_in_byte      (i_in_byte),
        .i_end_of_text  (i_end_of_text),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_token_kind   (o_token_kind),
        .o_start_offset (o_start_offset),
        .o_token_length (o_token_length),
        .o_int_value    (o_int_value),
        .o_last_of_run  (o_last_of_run)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Receiver ready: random idling, or a counted hold-off when requested
    initial begin : ready_drive
        int hold_left;
        hold_left = 0;
        i_ready   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= recv_idle);
            end
        end
    end

    // Output monitor: check every accepted token beat at the rising edge
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready)
                sb.check_token(o_token_kind, o_start_offset, o_token_length,
                               o_int_value, o_last_of_run);
        end
    end

    // Run limit, far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("timeout with %0d token beats still expected", sb.pending());
        $display("script_token_scanner: mismatch");
        $finish;
    end

    // Offer one byte beat, after random idle cycles, and hold it until taken
    task automatic send_item(input logic [7:0] b, input logic eot);
        while ($urandom_range(0, 99) < send_idle) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_in_byte     <= b;
        i_end_of_text <= eot;
        do @(posedge i_clk); while (!o_ready);
        sb.note_byte(b, eot);
    endtask

    // Drop valid and hold until every expected token has come out
    task automatic drain_tokens();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Send a literal text followed by the end mark
    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    function automatic logic [7:0] blank_char();
        case ($urandom_range(0, 3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    function automatic logic [7:0] letter_char();
        if ($urandom_range(0, 1)) return 8'("a" + $urandom_range(0, 25));
        return 8'("A" + $urandom_range(0, 25));
    endfunction

    // Build one mostly well-formed program from random tokens, then send it
    task automatic send_program();
        logic [7:0] txt[$];
        logic [7:0] b;
        string      w;
        int         ntok;
        int         len;
        ntok = $urandom_range(3, 14);
        for (int t = 0; t < ntok; t++) begin
            case ($urandom_range(0, 11))
                0: begin
                    w = kw_names[$urandom_range(0, 3)];
                    for (int i = 0; i < w.len(); i++) txt.push_back(w[i]);
                end
                1, 2: begin
                    len = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 14)
                                                       : $urandom_range(1, 6);
                    repeat (len) txt.push_back(letter_char());
                end
                3: begin
                    // keyword prefix or keyword with a letter appended
                    w = kw_names[$urandom_range(0, 3)];
                    if ($urandom_range(0, 1)) begin
                        for (int i = 0; i < w.len() - 1; i++) txt.push_back(w[i]);
                    end else begin
                        for (int i = 0; i < w.len(); i++) txt.push_back(w[i]);
                        txt.push_back(letter_char());
                    end
                end
                4: begin
                    len = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 13)
                                                      : $urandom_range(1, 4);
                    repeat (len) txt.push_back(8'("0" + $urandom_range(0, 9)));
                end
                5: begin
                    txt.push_back(CH_QUOTE);
                    repeat ($urandom_range(0, 6)) begin
                        do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE);
                        txt.push_back(b);
                    end
                    txt.push_back(CH_QUOTE);
                end
                6, 7: begin
                    w = ",;(){}";
                    txt.push_back(w[$urandom_range(0, 5)]);
                end
                8: begin
                    w = "+-*/=";
                    txt.push_back(w[$urandom_range(0, 4)]);
                end
                9: begin
                    txt.push_back(CH_HASH);
                    repeat ($urandom_range(0, 5)) begin
                        do b = 8'($urandom_range(0, 255)); while (b == CH_LF);
                        txt.push_back(b);
                    end
                    txt.push_back(CH_LF);
                end
                10: txt.push_back(blank_char());
                default: begin
                    // noise byte: often an unknown character that halts the scan
                    if ($urandom_range(0, 3) == 0) txt.push_back(8'($urandom_range(0, 255)));
                    else txt.push_back(CH_SPACE);
                end
            endcase
            if ($urandom_range(0, 3) != 0) txt.push_back(blank_char());
        end
        // Occasionally leave something open at the end of the text
        case ($urandom_range(0, 9))
            0: begin
                txt.push_back(CH_QUOTE);
                repeat ($urandom_range(0, 3)) txt.push_back(letter_char());
            end
            1: begin
                txt.push_back(CH_HASH);
                repeat ($urandom_range(0, 3)) txt.push_back(letter_char());
            end
            2: begin
                w = "+-*/=";
                repeat ($urandom_range(2, 4)) txt.push_back(w[$urandom_range(0, 4)]);
            end
            3: txt.push_back(8'($urandom_range(0, 255)));
            default: ;
        endcase
        foreach (txt[i]) send_item(txt[i], 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    initial begin : main_flow
        int base;
        int guard;
        string p;

        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_in_byte     = '0;
        i_end_of_text = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed texts: every token family and each corner of the scanner
        send_text("9,\"a");          // integer, comma, string left open at the end
        send_text("+=x");            // operator run, then the ending byte is dropped
        send_item(8'hFF, 1'b0);      // unknown character halts
        send_item("a", 1'b0);        // ignored while halted
        send_item(8'h5A, 1'b1);
        send_text("#c");             // comment closed by the end mark only
        send_item(8'h00, 1'b0);      // lowest byte is an unknown character
        send_item(8'hA5, 1'b1);
        send_text("if;/");           // keyword, semicolon, lone operator at the end
        drain_tokens();

        // Phase 1: sender idles a little, receiver idles a lot
        send_idle = 19;
        recv_idle = 86;
        base = sb.items;
        while (sb.items - base < 245) send_program();
        drain_tokens();

        // Phase 2: the other way round
        send_idle = 86;
        recv_idle = 19;
        base = sb.items;
        while (sb.items - base < 245) send_program();
        drain_tokens();

        // Phase 3: no idling; first stall the output so the input backs up
        send_idle = 0;
        recv_idle = 0;
        hold_req  = 150;
        p = ",;(){}";
        repeat (40) send_item(p[$urandom_range(0, 5)], 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b1);
        drain_tokens();

        base = sb.items;
        while (sb.items - base < 245) send_program();

        @(negedge i_clk);
        i_valid <= 1'b0;
        guard = 0;
        while (sb.pending() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (16) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $display("%0t: %0d expected token beats never arrived", $time, sb.pending());
            sb.errors += sb.pending();
        end

        $display("Covered %0d byte beats: directed corner texts, random programs under",
                 sb.items);
        $display("three idle mixes and an output stall burst; %0d token beats checked, %0d errors",
                 sb.checked, sb.errors);
        if (sb.errors == 0) begin
            $display("script_token_scanner: match");
        end else begin
            $display("script_token_scanner: mismatch");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/stc_pkg.sv
sv/stc_front.sv
sv/stc_queue.sv
sv/stc_back.sv
sv/script_token_scanner.sv
sim/tb_top.sv
